>>> rtl/blr_pkg.sv
package blr_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_PATCH = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_LINE_NUM = 2'd1;
	localparam logic [1:0] ERR_CHAIN    = 2'd2;

	// register index, taken from paddr bit 2
	localparam logic REG_LOAD_ADDR   = 1'b0;
	localparam logic REG_ESCAPE_MODE = 1'b1;

	// escape tokens and their payload lengths
	localparam logic [7:0] TOK_INT2_A = 8'h0E;
	localparam logic [7:0] TOK_INT2_B = 8'h1C;
	localparam logic [7:0] TOK_INT4   = 8'h1D;
	localparam logic [2:0] ESC_LEN2   = 3'd2;
	localparam logic [2:0] ESC_LEN4   = 3'd4;

	// input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] offset;
		logic [7:0]  value;
		logic [1:0]  error_code;
		logic [15:0] length;
		logic        last;
	} out_item_t;

	// all results caused by one input item, n of them valid (1 to 3)
	typedef struct packed {
		logic [1:0]            n;
		out_item_t [2:0]       res;
	} group_t;

endpackage

>>> rtl/blr_front.sv
module blr_front import blr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  in_item_t    item,
	input  logic [15:0] load_address,
	input  logic        escape_mode,
	output logic        push,
	output group_t      grp
);

	typedef enum logic [2:0] {
		PH_PTR_LO,
		PH_PTR_HI,
		PH_NUM_LO,
		PH_NUM_HI,
		PH_BODY,
		PH_HALT
	} phase_t;

	phase_t      phase_q, phase_e, phase_n;
	logic [15:0] pos_q, pos_e, pos_n;
	logic [15:0] ls_q, ls_e, ls_n;
	logic [15:0] prev_q, prev_e, prev_n;
	logic        havep_q, havep_e, havep_n;
	logic [15:0] cb_q, cb_e, cb_n;
	logic [15:0] ll_q, ll_e, ll_n;
	logic [15:0] cp_q, cp_e, cp_n;
	logic [7:0]  held_q, held_e, held_n;
	logic [2:0]  esc_q, esc_e, esc_n;

	logic [15:0] ptr, num, ll_inc, pos_inc, patch;
	logic [16:0] want;
	logic [7:0]  b;

	function automatic out_item_t mk(logic [1:0] kind, logic [15:0] off, logic [7:0] val,
			logic [1:0] err, logic [15:0] len);
		out_item_t r;
		r.kind       = kind;
		r.offset     = off;
		r.value      = val;
		r.error_code = err;
		r.length     = len;
		r.last       = 1'b0;
		return r;
	endfunction

	// effective state: a start request clears parsing before this byte
	always_comb begin
		if (item.start_req) begin
			phase_e = PH_PTR_LO;
			pos_e   = '0;
			ls_e    = '0;
			prev_e  = '0;
			havep_e = 1'b0;
			cb_e    = '0;
			ll_e    = '0;
			cp_e    = '0;
			held_e  = '0;
			esc_e   = '0;
		end else begin
			phase_e = phase_q;
			pos_e   = pos_q;
			ls_e    = ls_q;
			prev_e  = prev_q;
			havep_e = havep_q;
			cb_e    = cb_q;
			ll_e    = ll_q;
			cp_e    = cp_q;
			held_e  = held_q;
			esc_e   = esc_q;
		end
	end

	assign b       = item.data_byte;
	assign ptr     = {b, cp_e[7:0]};
	assign num     = {b, held_e};
	assign ll_inc  = ll_e + 16'd1;
	assign pos_inc = pos_e + 16'd1;
	assign want    = {1'b0, cb_e} + {1'b0, ll_inc};
	assign patch   = load_address + pos_inc;

	// parse one byte
	always_comb begin
		phase_n = phase_e;
		pos_n   = pos_inc;
		ls_n    = ls_e;
		prev_n  = prev_e;
		havep_n = havep_e;
		cb_n    = cb_e;
		ll_n    = ll_e;
		cp_n    = cp_e;
		held_n  = held_e;
		esc_n   = esc_e;
		push    = 1'b0;
		grp     = '0;
		unique case (phase_e)
			PH_PTR_LO: begin
				cp_n    = {8'h00, b};
				ll_n    = ll_inc;
				phase_n = PH_PTR_HI;
			end
			PH_PTR_HI: begin
				cp_n = ptr;
				if (ptr == 16'h0000) begin
					push       = 1'b1;
					grp.n      = 2'd3;
					grp.res[0] = mk(KIND_DATA, pos_e - 16'd1, 8'h00, ERR_NONE, 16'h0000);
					grp.res[1] = mk(KIND_DATA, pos_e, 8'h00, ERR_NONE, 16'h0000);
					grp.res[2] = mk(KIND_DONE, 16'h0000, 8'h00, ERR_NONE, pos_inc);
					phase_n    = PH_HALT;
				end else begin
					ll_n    = ll_inc;
					phase_n = PH_NUM_LO;
				end
			end
			PH_NUM_LO: begin
				held_n  = b;
				ll_n    = ll_inc;
				phase_n = PH_NUM_HI;
			end
			PH_NUM_HI: begin
				push = 1'b1;
				if (havep_e && num <= prev_e) begin
					grp.n      = 2'd1;
					grp.res[0] = mk(KIND_ERROR, 16'h0000, 8'h00, ERR_LINE_NUM, 16'h0000);
					phase_n    = PH_HALT;
				end else begin
					prev_n     = num;
					havep_n    = 1'b1;
					grp.n      = 2'd2;
					grp.res[0] = mk(KIND_DATA, pos_e - 16'd1, held_e, ERR_NONE, 16'h0000);
					grp.res[1] = mk(KIND_DATA, pos_e, b, ERR_NONE, 16'h0000);
					ll_n       = ll_inc;
					esc_n      = '0;
					phase_n    = PH_BODY;
				end
			end
			PH_BODY: begin
				push       = 1'b1;
				ll_n       = ll_inc;
				grp.n      = 2'd1;
				grp.res[0] = mk(KIND_DATA, pos_e, b, ERR_NONE, 16'h0000);
				if (esc_e != 3'd0) begin
					esc_n = esc_e - 3'd1;
				end else if (b == 8'h00) begin
					// line end: check the chain, then patch the pointer
					if (ls_e != 16'h0000 && {1'b0, cp_e} != want) begin
						grp.n      = 2'd2;
						grp.res[1] = mk(KIND_ERROR, 16'h0000, 8'h00, ERR_CHAIN, 16'h0000);
						phase_n    = PH_HALT;
					end else begin
						grp.n      = 2'd3;
						grp.res[1] = mk(KIND_PATCH, ls_e, patch[7:0], ERR_NONE, 16'h0000);
						grp.res[2] = mk(KIND_PATCH, ls_e + 16'd1, patch[15:8], ERR_NONE,
							16'h0000);
						cb_n       = cp_e;
						ls_n       = pos_inc;
						ll_n       = '0;
						phase_n    = PH_PTR_LO;
					end
				end else if (escape_mode) begin
					if (b == TOK_INT2_A || b == TOK_INT2_B) begin
						esc_n = ESC_LEN2;
					end else if (b == TOK_INT4) begin
						esc_n = ESC_LEN4;
					end
				end
			end
			PH_HALT: begin
				pos_n = pos_e;
			end
			default: begin
				pos_n = pos_e;
			end
		endcase
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PTR_LO;
			pos_q   <= '0;
			ls_q    <= '0;
			prev_q  <= '0;
			havep_q <= 1'b0;
			cb_q    <= '0;
			ll_q    <= '0;
			cp_q    <= '0;
			held_q  <= '0;
			esc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			ls_q    <= ls_n;
			prev_q  <= prev_n;
			havep_q <= havep_n;
			cb_q    <= cb_n;
			ll_q    <= ll_n;
			cp_q    <= cp_n;
			held_q  <= held_n;
			esc_q   <= esc_n;
		end
	end

endmodule

>>> rtl/blr_queue.sv
module blr_queue import blr_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_grp,
	input  logic   pop,
	output group_t head,
	output logic   full,
	output logic   empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	group_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] nxt(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/blr_back.sv
module blr_back import blr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  group_t    head,
	input  logic      empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic [1:0] sub_q;
	logic       is_last;

	assign out_valid = !empty;
	assign is_last   = (sub_q == head.n - 2'd1);
	assign pop       = out_valid && out_ready && is_last;

	// pick the current result of the head group
	always_comb begin
		case (sub_q)
			2'd1:    out_item = head.res[1];
			2'd2:    out_item = head.res[2];
			default: out_item = head.res[0];
		endcase
		out_item.last = is_last;
	end

	// result index within the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (out_valid && out_ready) begin
			sub_q <= is_last ? 2'd0 : sub_q + 2'd1;
		end
	end

endmodule

>>> rtl/basic_line_relocator.sv
// channel  | direction | payload      | handshake
// byte     | in        | in_item_t    | byte_valid / byte_ready
// result   | out       | out_item_t   | result_valid / result_ready
// config   | in        | apb, 32 bits | psel / penable / pwrite, pready tied high
//
// one input item is accepted per cycle while the group queue has room; the
// parser classifies it in the cycle it is taken.
// each item yields zero to three results; the back end sends one result per
// cycle while result_ready is high, so sustained rate is set by the result port.
// asynchronous reset clears parse state, queue and registers; no clearing pass.
// a stalled result port fills the QDEPTH-entry queue, then byte_ready drops.
module basic_line_relocator import blr_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  in_item_t    byte_item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] load_address_q;
	logic        escape_mode_q;
	logic        accept, push, pop, full, empty;
	group_t      grp, head;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_address_q <= '0;
			escape_mode_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_LOAD_ADDR:   load_address_q <= pwdata[15:0];
				REG_ESCAPE_MODE: escape_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LOAD_ADDR:   prdata = {16'h0000, load_address_q};
			REG_ESCAPE_MODE: prdata = {31'h0, escape_mode_q};
			default:         prdata = '0;
		endcase
	end

	// front end: accept and parse
	assign byte_ready = !full;
	assign accept     = byte_valid && byte_ready;

	blr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (byte_item),
		.load_address (load_address_q),
		.escape_mode  (escape_mode_q),
		.push         (push),
		.grp          (grp)
	);

	// result group queue
	blr_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && push),
		.push_grp (grp),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	// back end: one result per cycle while result_ready is high
	blr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_item  (result_item)
	);

	// an error or finished result always closes its group
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_item.kind == KIND_ERROR || result_item.kind == KIND_DONE)
		|-> result_item.last)
		else $error("error or finished result not marked last");

	// error code only on error results
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.kind != KIND_ERROR |-> result_item.error_code == ERR_NONE)
		else $error("error code on a non-error result");

	// length only on finished results
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.kind != KIND_DONE |-> result_item.length == 16'h0000)
		else $error("length on a non-finished result");

	// input is held off only when the queue is full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> result_valid)
		else $error("input stalled with an empty queue");

endmodule
